// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the converter, included by its top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An antecedent that must be followed by a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An antecedent that must be followed by a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/vocppm_pkg.sv
// Package with the constants and widths of the VOC concentration converter.
`default_nettype none

package vocppm_pkg;

   // Sample width default and register port geometry.
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int CSR_DATA_W      = 16;
   localparam int CSR_INDEX_W     = 1;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAN_AIR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOAD      = 1'd1;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] CLEAN_AIR_RESET = 16'd29198;
   localparam logic [CSR_DATA_W-1:0] LOAD_RESET      = 16'd5600;

   // Divider node constant and the sample at which the resistance reaches zero.
   localparam int DIVIDER_CONST = 6204;
   localparam int HALF_POINT    = 3102;

   // Widths of the two divisions. Samples below the half point fit DEN1_W bits.
   localparam int DEN1_W = $clog2(HALF_POINT);
   localparam int DIFF_W = $clog2(DIVIDER_CONST + 1);
   localparam int NUM1_W = DIFF_W + CSR_DATA_W;
   localparam int NUM2_W = $clog2(((1 << CSR_DATA_W) - 1) * 10 + 1);
   localparam int DEN2_W = NUM1_W;

   // Curve segment bounds and coefficients.
   localparam int SEG1_LO  = 13;
   localparam int SEG2_LO  = 20;
   localparam int SEG3_LO  = 33;
   localparam int SEG4_LO  = 83;
   localparam int SEG5_LO  = 233;
   localparam int SEG6_LO  = 350;
   localparam int SEG1_MUL = 286;
   localparam int SEG1_SUB = 2710;
   localparam int SEG2_MUL = 538;
   localparam int SEG2_SUB = 7760;
   localparam int SEG3_ADD = 4;
   localparam int SEG4_ADD = 14;
   localparam int PPM_MAX  = 30;
   localparam int PPM_W    = 5;

   // Reciprocals: x / 5 = (x * 205) >> 10 below 1024, x / 15 = (x * 137) >> 11
   // below 256, and v / 1000 = ((v >> 3) * 1049) >> 17 below 19992.
   localparam int RCP5_MUL    = 205;
   localparam int RCP5_SHIFT  = 10;
   localparam int RCP15_MUL   = 137;
   localparam int RCP15_SHIFT = 11;
   localparam int RCPK_PRE    = 3;
   localparam int RCPK_MUL    = 1049;
   localparam int RCPK_SHIFT  = 17;

endpackage : vocppm_pkg

`default_nettype wire

// File: hw/rtl/voc_adc_to_ppm_converter.sv
// Throughput: one item per cycle unless the output buffer holds two results;
// the two divisions are pipelined at one quotient bit per stage (29 stages,
// then 20 stages). A two-entry output buffer lets the pipeline run on while
// one result waits. Reset (synchronous) empties the pipeline and restores
// both registers.
`default_nettype none

module voc_adc_to_ppm_converter #(
   parameter int SAMPLE_BITS = vocppm_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // tdata: adc_sample [SAMPLE_BITS-1:0], zero padding above.
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // tdata: ppm [4:0], saturated [5], zero padding [7:6].
   output logic [7:0]                               rsp_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_we,
   input  wire logic [vocppm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [vocppm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import vocppm_pkg::*;

`include "assert_macros.svh"

   localparam int CMP_W = (SAMPLE_BITS > DEN1_W) ? SAMPLE_BITS : DEN1_W;
   localparam int WK_W  = CSR_DATA_W - RCPK_PRE;

   typedef enum logic [2:0] {
      SEG_ZERO, SEG_LOW, SEG_MID, SEG_FIFTH, SEG_FIFTEENTH, SEG_29, SEG_30
   } seg_type;

   typedef struct packed {
      logic zero;
      logic sat;
   } flags_type;

   typedef struct packed {
      logic             sat;
      logic [PPM_W-1:0] ppm;
   } result_type;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] r0_ff, rl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_ff <= CLEAN_AIR_RESET;
         rl_ff <= LOAD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLEAN_AIR: r0_ff <= csr_wdata;
            CSR_LOAD:      rl_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // The whole pipeline moves unless the output buffer holds two results.
   logic skid_valid_ff, skid_valid_in;
   logic en;

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // Stage 0: classify the sample and form 6204 - s.
   logic [CMP_W-1:0]  s_ext;
   logic              s0_valid_ff;
   flags_type         s0_flags_ff, s0_flags_in;
   logic [DEN1_W-1:0] s0_den_ff, s0_den_in;
   logic [DIFF_W-1:0] s0_diff_ff, s0_diff_in;

   always_comb begin
      s_ext            = CMP_W'(req_tdata[SAMPLE_BITS-1:0]);
      s0_flags_in.zero = (s_ext == '0);
      s0_flags_in.sat  = (s_ext >= CMP_W'(HALF_POINT));
      s0_den_in        = s_ext[DEN1_W-1:0];
      s0_diff_in       = DIFF_W'(DIVIDER_CONST) - DIFF_W'(s0_den_in);
   end

   // Stage 1: numerator (6204 - s) * RL.
   logic              s1_valid_ff;
   flags_type         s1_flags_ff;
   logic [DEN1_W-1:0] s1_den_ff;
   logic [NUM1_W-1:0] s1_num_ff, s1_num_in;

   assign s1_num_in = NUM1_W'(s0_diff_ff) * NUM1_W'(rl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_flags_ff <= s0_flags_in;
         s0_den_ff   <= s0_den_in;
         s0_diff_ff  <= s0_diff_in;
         s1_flags_ff <= s0_flags_ff;
         s1_den_ff   <= s0_den_ff;
         s1_num_ff   <= s1_num_in;
      end
   end

   // First division: q = (6204 - s) * RL / s.
   logic              d1_valid;
   logic [NUM1_W-1:0] d1_quot;
   flags_type         d1_flags;

   vocppm_div #(
      .NUM_W  (NUM1_W),
      .DEN_W  (DEN1_W),
      .SIDE_W ($bits(flags_type))
   ) u_div_rs (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (s1_valid_ff),
      .in_num    (s1_num_ff),
      .in_den    (s1_den_ff),
      .in_side   (s1_flags_ff),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_side  (d1_flags)
   );

   // Stage 3: rs = q - RL, saturate when q does not exceed RL, and R0 * 10.
   logic              s3_valid_ff;
   flags_type         s3_flags_ff, s3_flags_in;
   logic [DEN2_W-1:0] s3_rs_ff, s3_rs_in;
   logic [NUM2_W-1:0] s3_num_ff, s3_num_in;

   always_comb begin
      s3_flags_in.zero = d1_flags.zero;
      s3_flags_in.sat  = d1_flags.sat || (d1_quot <= NUM1_W'(rl_ff));
      s3_rs_in         = DEN2_W'(d1_quot) - DEN2_W'(rl_ff);
      s3_num_in        = (NUM2_W'(r0_ff) << 3) + (NUM2_W'(r0_ff) << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_flags_ff <= s3_flags_in;
         s3_rs_ff    <= s3_rs_in;
         s3_num_ff   <= s3_num_in;
      end
   end

   // Second division: x = R0 * 10 / rs.
   logic              d2_valid;
   logic [NUM2_W-1:0] d2_quot;
   flags_type         d2_flags;

   vocppm_div #(
      .NUM_W  (NUM2_W),
      .DEN_W  (DEN2_W),
      .SIDE_W ($bits(flags_type))
   ) u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_rs_ff),
      .in_side   (s3_flags_ff),
      .out_valid (d2_valid),
      .out_quot  (d2_quot),
      .out_side  (d2_flags)
   );

   // Curve stage 1: pick the segment and form the segment products.
   logic              c1_valid_ff;
   flags_type         c1_flags_ff;
   seg_type           c1_seg_ff, c1_seg_in;
   logic [15:0]       c1_lin_ff, c1_lin_in;
   logic [PPM_W-1:0]  c1_q5_ff, c1_q5_in;
   logic [PPM_W-1:0]  c1_q15_ff, c1_q15_in;
   logic [5:0]        x6;
   logic [6:0]        x7;
   logic [7:0]        x8;
   logic [14:0]       p5;
   logic [15:0]       p15;

   always_comb begin
      x6 = d2_quot[5:0];
      x7 = d2_quot[6:0];
      x8 = d2_quot[7:0];
      if (d2_quot < NUM2_W'(SEG1_LO)) begin
         c1_seg_in = SEG_ZERO;
      end else if (d2_quot < NUM2_W'(SEG2_LO)) begin
         c1_seg_in = SEG_LOW;
      end else if (d2_quot < NUM2_W'(SEG3_LO)) begin
         c1_seg_in = SEG_MID;
      end else if (d2_quot < NUM2_W'(SEG4_LO)) begin
         c1_seg_in = SEG_FIFTH;
      end else if (d2_quot < NUM2_W'(SEG5_LO)) begin
         c1_seg_in = SEG_FIFTEENTH;
      end else if (d2_quot < NUM2_W'(SEG6_LO)) begin
         c1_seg_in = SEG_29;
      end else begin
         c1_seg_in = SEG_30;
      end
      // The two steep segments share one linear term before the divide by 1000.
      if (c1_seg_in == SEG_LOW) begin
         c1_lin_in = 16'(16'(x6) * 16'(SEG1_MUL)) - 16'(SEG1_SUB);
      end else begin
         c1_lin_in = 16'(16'(x6) * 16'(SEG2_MUL)) - 16'(SEG2_SUB);
      end
      p5        = 15'(x7) * 15'(RCP5_MUL);
      p15       = 16'(x8) * 16'(RCP15_MUL);
      c1_q5_in  = PPM_W'(p5 >> RCP5_SHIFT);
      c1_q15_in = PPM_W'(p15 >> RCP15_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_valid_ff <= 1'b0;
      end else if (en) begin
         c1_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_flags_ff <= d2_flags;
         c1_seg_ff   <= c1_seg_in;
         c1_lin_ff   <= c1_lin_in;
         c1_q5_ff    <= c1_q5_in;
         c1_q15_ff   <= c1_q15_in;
      end
   end

   // Curve stage 2: divide the linear term by 1000, select, cap and flag.
   logic [WK_W-1:0]          lin_w;
   logic [WK_W+10:0]         lin_p;
   logic [PPM_W:0]           curve;
   result_type               res;

   always_comb begin
      lin_w = c1_lin_ff[CSR_DATA_W-1:RCPK_PRE];
      lin_p = (WK_W + 11)'(lin_w) * (WK_W + 11)'(RCPK_MUL);
      case (c1_seg_ff)
         SEG_ZERO:      curve = '0;
         SEG_LOW,
         SEG_MID:       curve = (PPM_W + 1)'(lin_p >> RCPK_SHIFT);
         SEG_FIFTH:     curve = (PPM_W + 1)'(c1_q5_ff) + (PPM_W + 1)'(SEG3_ADD);
         SEG_FIFTEENTH: curve = (PPM_W + 1)'(c1_q15_ff) + (PPM_W + 1)'(SEG4_ADD);
         SEG_29:        curve = (PPM_W + 1)'(PPM_MAX - 1);
         SEG_30:        curve = (PPM_W + 1)'(PPM_MAX);
         default:       curve = (PPM_W + 1)'(PPM_MAX);
      endcase
      if (curve > (PPM_W + 1)'(PPM_MAX)) begin
         curve = (PPM_W + 1)'(PPM_MAX);
      end
      if (c1_flags_ff.zero) begin
         res.ppm = '0;
         res.sat = 1'b0;
      end else if (c1_flags_ff.sat) begin
         res.ppm = PPM_W'(PPM_MAX);
         res.sat = 1'b1;
      end else begin
         res.ppm = curve[PPM_W-1:0];
         res.sat = 1'b0;
      end
   end

   // Output register with one skid entry behind it.
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       take;

   always_comb begin
      take          = out_valid_ff && rsp_tready;
      out_valid_in  = out_valid_ff && !take;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (c1_valid_ff) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_data_ff.sat, out_data_ff.ppm};

   // The skid entry is only ever filled behind a waiting result.
   `ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid full with output empty")
   // A saturated result always reads as the ceiling.
   `ASSERT_IMPLY(a_sat_is_max, clock, reset, rsp_tvalid && out_data_ff.sat, out_data_ff.ppm == PPM_W'(PPM_MAX), "saturated result not at ceiling")
   // No result exceeds the ceiling.
   `ASSERT_IMPLY(a_ppm_range, clock, reset, rsp_tvalid, out_data_ff.ppm <= PPM_W'(PPM_MAX), "ppm above ceiling")
   // A full buffer stops new items until the waiting result drains.
   `ASSERT_NEXT(a_stall_on_full, clock, reset, skid_valid_ff && !rsp_tready, !req_tready, "input taken while buffer full")

endmodule : voc_adc_to_ppm_converter

`default_nettype wire

// File: hw/rtl/vocppm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`default_nettype none

module vocppm_div #(
   parameter int NUM_W  = 29,
   parameter int DEN_W  = 12,
   parameter int SIDE_W = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quot,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int ACC_W = DEN_W + NUM_W;

   // Per stage: partial remainder above the numerator bits still to shift in.
   logic [ACC_W-1:0]  acc_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff   [NUM_W];
   logic [SIDE_W-1:0] side_ff  [NUM_W];
   logic              valid_ff [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic [ACC_W-1:0]  acc_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [ACC_W:0]    shifted;
      logic [DEN_W:0]    top;
      logic [DEN_W:0]    diff;
      logic [ACC_W-1:0]  acc_in;

      if (i == 0) begin : g_first
         assign acc_prev   = {{DEN_W{1'b0}}, in_num};
         assign den_prev   = in_den;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign acc_prev   = acc_ff[i-1];
         assign den_prev   = den_ff[i-1];
         assign side_prev  = side_ff[i-1];
         assign valid_prev = valid_ff[i-1];
      end

      // Shift one numerator bit in and subtract the divisor where it fits.
      always_comb begin
         shifted = {acc_prev, 1'b0};
         top     = shifted[ACC_W:NUM_W];
         diff    = top - {1'b0, den_prev};
         if (top >= {1'b0, den_prev}) begin
            acc_in = {diff[DEN_W-1:0], shifted[NUM_W-1:1], 1'b1};
         end else begin
            acc_in = shifted[ACC_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            acc_ff[i]  <= acc_in;
            den_ff[i]  <= den_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   // The quotient has filled the low bits after the last stage.
   assign out_valid = valid_ff[NUM_W-1];
   assign out_quot  = acc_ff[NUM_W-1][NUM_W-1:0];
   assign out_side  = side_ff[NUM_W-1];

endmodule : vocppm_div

`default_nettype wire

// File: bench/voc_adc_to_ppm_converter_tb.sv
// Self-checking testbench for the VOC sample to ppm converter.
`timescale 1ns / 100ps

module voc_adc_to_ppm_converter_tb;

   import vocppm_pkg::*;

   localparam int ADC_W   = SAMPLE_BITS_DEF;
   localparam int REQ_W   = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
   localparam int TAIL    = 80;
   localparam int PHASES  = 20;
   localparam int PER_PHASE = 61;

   // Expected result of one sample, with the sample kept for reporting.
   typedef struct packed {
      logic [ADC_W-1:0] sample;
      logic [4:0]       ppm;
      logic             saturated;
   } voc_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Bench copies of the two resistance registers.
   logic [15:0]           clean_air_cfg = CLEAN_AIR_RESET;
   logic [15:0]           load_cfg = LOAD_RESET;

   logic [ADC_W-1:0]      sample_q[$];
   voc_result_type        ppm_expect_q[$];
   int                    error_count = 0;

   int                    req_gap = 0;
   int                    req_burst = 0;
   logic                  req_busy;
   int                    rsp_stall = 0;
   int                    rsp_burst = 0;

   voc_adc_to_ppm_converter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Concentration expected for one sample under the given resistances.
   function automatic voc_result_type predict_voc(logic [ADC_W-1:0] sample, logic [15:0] r0,
                                                  logic [15:0] rl);
      voc_result_type res;
      longint unsigned s, q, rs, x, y;
      res.sample = sample;
      res.ppm = 5'd0;
      res.saturated = 1'b0;
      s = sample;
      if (s == 0) begin
         res.ppm = 5'd0;
      end else if (s >= 3102) begin
         res.ppm = 5'd30;
         res.saturated = 1'b1;
      end else begin
         q = ((64'd6204 - s) * rl) / s;
         if (q <= rl) begin
            res.ppm = 5'd30;
            res.saturated = 1'b1;
         end else begin
            rs = q - rl;
            x = (r0 * 64'd10) / rs;
            // Seven-segment curve with integer divisions.
            if (x < 13) y = 0;
            else if (x < 20) y = (286 * x - 2710) / 1000;
            else if (x < 33) y = (538 * x - 7760) / 1000;
            else if (x < 83) y = x / 5 + 4;
            else if (x < 233) y = x / 15 + 14;
            else if (x < 350) y = 29;
            else y = 30;
            if (y > 30) y = 30;
            res.ppm = y[4:0];
         end
      end
      return res;
   endfunction

   // Gap length: mostly none or short, a few long, and now and then a run without gaps.
   function automatic int draw_gap(inout int burst_left);
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Sample drawn mostly from the range that reaches the curve.
   function automatic logic [ADC_W-1:0] draw_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return ADC_W'($urandom_range(1, 3101));
      if (r < 80) return ADC_W'($urandom_range(3102, 4095));
      if (r < 85) return '0;
      return ADC_W'($urandom_range(0, 4095));
   endfunction

   // Driver: presents queued samples and records the expectation of each accepted item.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         req_busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            ppm_expect_q.push_back(predict_voc(req_tdata[ADC_W-1:0], clean_air_cfg, load_cfg));
            req_busy = 1'b0;
         end
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               req_tdata <= REQ_W'(sample_q.pop_front());
               req_tvalid <= 1'b1;
               req_gap = draw_gap(req_burst);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      voc_result_type exp_res;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (ppm_expect_q.size() == 0) begin
               $display("%0t: unexpected result, actual ppm %0d saturated %0d", $time,
                        rsp_tdata[4:0], rsp_tdata[5]);
               error_count++;
            end else begin
               exp_res = ppm_expect_q.pop_front();
               if (rsp_tdata[4:0] !== exp_res.ppm) begin
                  $display("%0t: sample %0d ppm mismatch, expected %0d actual %0d", $time,
                           exp_res.sample, exp_res.ppm, rsp_tdata[4:0]);
                  error_count++;
               end
               if (rsp_tdata[5] !== exp_res.saturated) begin
                  $display("%0t: sample %0d saturated mismatch, expected %0d actual %0d",
                           $time, exp_res.sample, exp_res.saturated, rsp_tdata[5]);
                  error_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_stall = draw_gap(rsp_burst);
         end
      end
   end

   // Register write, only issued while the converter is idle.
   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_CLEAN_AIR) clean_air_cfg = value;
      else if (index == CSR_LOAD) load_cfg = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every queued sample has been sent and every result has arrived.
   task automatic wait_drained();
      do @(negedge clock);
      while (sample_q.size() != 0 || req_tvalid || ppm_expect_q.size() != 0);
      repeat (TAIL) @(posedge clock);
   endtask

   // Stimulus: directed samples at reset values, then phases of register settings.
   initial begin
      logic [15:0] r0_set[6];
      logic [15:0] rl_set[6];
      logic [15:0] r0_val;
      logic [15:0] rl_val;
      r0_set = '{16'd65535, 16'd1, 16'd0, 16'd29198, 16'd1, 16'd65535};
      rl_set = '{16'd65535, 16'd1, 16'd5600, 16'd0, 16'd65535, 16'd1};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Field extremes, the zero sample and the samples around the half point.
      sample_q.push_back(12'd0);
      sample_q.push_back(12'd1);
      sample_q.push_back(12'd4095);
      sample_q.push_back(12'd3101);
      sample_q.push_back(12'd3102);
      sample_q.push_back(12'd3103);
      sample_q.push_back(12'd2048);
      sample_q.push_back(12'd2047);
      sample_q.push_back(12'd2730);
      // A sweep across the curve segments at the reset resistances.
      for (int s = 1000; s <= 3100; s += 150) sample_q.push_back(ADC_W'(s));
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 6) begin
            r0_val = r0_set[ph];
            rl_val = rl_set[ph];
         end else begin
            r0_val = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 65535))
                                                 : 16'($urandom_range(10000, 60000));
            rl_val = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 65535))
                                                 : 16'($urandom_range(1000, 20000));
         end
         write_reg(CSR_CLEAN_AIR, r0_val);
         write_reg(CSR_LOAD, rl_val);
         for (int i = 0; i < PER_PHASE; i++) sample_q.push_back(draw_sample());
         wait_drained();
      end

      // Back to the reset values before the end.
      write_reg(CSR_CLEAN_AIR, CLEAN_AIR_RESET);
      write_reg(CSR_LOAD, LOAD_RESET);
      for (int i = 0; i < PER_PHASE; i++) sample_q.push_back(draw_sample());
      wait_drained();

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog on the whole run.
   initial begin
      #10000000;
      $display("%0t: timeout with %0d results outstanding", $time, ppm_expect_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
